// ===== hdl/doubly_linked_list_cursor_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the list cursor engine
// Concurrent assertion shorthands, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_CURSOR_ENGINE_UNIT_ASSERT_SVH
`define DOUBLY_LINKED_LIST_CURSOR_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DLLCE_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("list engine assertion failed");

// Next-cycle implication.
`define DLLCE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("list engine assertion failed");

`endif

// ===== hdl/dllce_pkg.sv =====
// ----------------------------------------------------------------------------
// dllce_pkg
// Shared types and constants of the list cursor engine.
// ----------------------------------------------------------------------------
package dllce_pkg;

  localparam int OP_W  = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 5'd0,
    OP_INS_HEAD   = 5'd1,
    OP_INS_TAIL   = 5'd2,
    OP_CUR_HEAD   = 5'd3,
    OP_CUR_TAIL   = 5'd4,
    OP_GET_HEAD   = 5'd5,
    OP_GET_TAIL   = 5'd6,
    OP_DEL_HEAD   = 5'd7,
    OP_DEL_TAIL   = 5'd8,
    OP_DEL_AFTER  = 5'd9,
    OP_DEL_BEFORE = 5'd10,
    OP_INS_AFTER  = 5'd11,
    OP_INS_BEFORE = 5'd12,
    OP_GET_CUR    = 5'd13,
    OP_SET_CUR    = 5'd14,
    OP_NEXT       = 5'd15,
    OP_PREV       = 5'd16
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } st_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WR1,
    S_WR2,
    S_DONE
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the accepted transaction
    logic rd2;    // second, dependent memory read
    logic wr1;    // first write phase and register update
    logic wr2;    // second write phase
    logic emit;   // load the output register
  } cmd_t;

endpackage

// ===== hdl/dllce_ctrl.sv =====
// ----------------------------------------------------------------------------
// dllce_ctrl
// Sequencer: accept, two reads, two write phases, hand off to output register.
// ----------------------------------------------------------------------------
module dllce_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dllce_pkg::cmd_t  cmd_o
);
  import dllce_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD1;
        end
      end
      S_RD1: state_d = S_RD2;
      S_RD2: begin
        cmd_o.rd2 = 1'b1;
        state_d   = S_WR1;
      end
      S_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = S_WR2;
      end
      S_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/dllce_dpath.sv =====
// ----------------------------------------------------------------------------
// dllce_dpath
// Node pool memories, list registers, free chain and output register.
// ----------------------------------------------------------------------------
module dllce_dpath #(
  parameter int CAPACITY = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dllce_pkg::cmd_t                       cmd_i,
  input  logic [dllce_pkg::OP_W-1:0]            op_i,
  input  logic signed [dllce_pkg::VAL_W-1:0]    value_i,
  output logic signed [dllce_pkg::VAL_W-1:0]    read_value_o,
  output logic [dllce_pkg::ST_W-1:0]            status_o,
  output logic                                  cursor_present_o,
  output logic [dllce_pkg::LEN_W-1:0]           length_o
);
  import dllce_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // node pool
  logic [VAL_W-1:0] val_mem  [CAPACITY];
  logic [IW-1:0]    next_mem [CAPACITY];
  logic [IW-1:0]    prev_mem [CAPACITY];

  // transaction
  logic [OP_W-1:0]         op_q;
  logic signed [VAL_W-1:0] val_q;

  // list state
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d, fhead_q, fhead_d;
  logic          cval_q, cval_d;
  logic [CW-1:0] cnt_q, cnt_d, unused_q, unused_d, fcnt_q, fcnt_d;

  // read data and first-read capture
  logic [VAL_W-1:0] rdv_q, t1v_q;
  logic [IW-1:0]    rdn_q, rdp_q, t1n_q, t1p_q;
  logic [IW-1:0]    raddr;

  // write ports, phase one
  logic             wv_en, wn_en, wp_en;
  logic [IW-1:0]    wv_a, wn_a, wp_a, wn_d, wp_d;
  logic [VAL_W-1:0] wv_d;

  // write ports, phase two (latched in phase one)
  logic          w2n_en_q, w2n_en_d, w2p_en_q, w2p_en_d;
  logic [IW-1:0] w2n_a_q, w2n_a_d, w2n_v_q, w2n_v_d;
  logic [IW-1:0] w2p_a_q, w2p_a_d, w2p_v_q, w2p_v_d;

  // result
  logic [VAL_W-1:0] res_rd_q, res_rd_d;
  st_e              res_st_q, res_st_d;

  // node allocation
  logic          tk_free, tk_ok;
  logic [IW-1:0] tk_n, tk_fhead;
  logic [CW-1:0] tk_fcnt, tk_unused;

  assign tk_free   = (fcnt_q != '0);
  assign tk_ok     = tk_free || (unused_q < CW'(CAPACITY));
  assign tk_n      = tk_free ? fhead_q : unused_q[IW-1:0];
  assign tk_fhead  = tk_free ? rdn_q : fhead_q;
  assign tk_fcnt   = tk_free ? fcnt_q - CW'(1) : fcnt_q;
  assign tk_unused = tk_free ? unused_q : unused_q + CW'(1);

  // first read address from op, second from first read or fhead_q
  always_comb begin
    raddr = cur_q;
    if (cmd_i.rd2) begin
      case (op_q)
        OP_DEL_AFTER:  raddr = rdn_q;
        OP_DEL_BEFORE: raddr = rdp_q;
        default:       raddr = fhead_q;
      endcase
    end else begin
      case (op_q)
        OP_GET_HEAD, OP_DEL_HEAD: raddr = head_q;
        OP_GET_TAIL, OP_DEL_TAIL: raddr = tail_q;
        default:                  raddr = cur_q;
      endcase
    end
  end

  always_comb begin
    head_d = head_q; tail_d = tail_q; cur_d = cur_q; cval_d = cval_q;
    cnt_d = cnt_q; unused_d = unused_q; fhead_d = fhead_q; fcnt_d = fcnt_q;
    res_rd_d = res_rd_q; res_st_d = res_st_q;
    wv_en = 1'b0; wv_a = '0; wv_d = '0;
    wn_en = 1'b0; wn_a = '0; wn_d = '0;
    wp_en = 1'b0; wp_a = '0; wp_d = '0;
    w2n_en_d = 1'b0; w2n_a_d = '0; w2n_v_d = '0;
    w2p_en_d = 1'b0; w2p_a_d = '0; w2p_v_d = '0;
    if (cmd_i.wr1) begin
      res_rd_d = '0;
      res_st_d = ST_OK;
      case (op_q)
        OP_CLEAR: begin
          cnt_d = '0; cval_d = 1'b0; unused_d = '0; fcnt_d = '0; fhead_d = '0;
        end
        OP_INS_HEAD, OP_INS_TAIL: begin
          if (!tk_ok) begin
            res_st_d = ST_FULL;
          end else begin
            fhead_d = tk_fhead; fcnt_d = tk_fcnt; unused_d = tk_unused;
            wv_en = 1'b1; wv_a = tk_n; wv_d = val_q;
            wn_en = 1'b1; wn_a = tk_n;
            wp_en = 1'b1; wp_a = tk_n;
            if (op_q == OP_INS_HEAD) begin
              wn_d = head_q;
              if (cnt_q == '0) begin
                tail_d = tk_n;
              end else begin
                w2p_en_d = 1'b1; w2p_a_d = head_q; w2p_v_d = tk_n;
              end
              head_d = tk_n;
            end else begin
              wp_d = tail_q;
              if (cnt_q == '0) begin
                head_d = tk_n;
              end else begin
                w2n_en_d = 1'b1; w2n_a_d = tail_q; w2n_v_d = tk_n;
              end
              tail_d = tk_n;
            end
            cnt_d = cnt_q + CW'(1);
          end
        end
        OP_CUR_HEAD, OP_CUR_TAIL: begin
          cur_d  = (op_q == OP_CUR_HEAD) ? head_q : tail_q;
          cval_d = (cnt_q != '0);
        end
        OP_GET_HEAD, OP_GET_TAIL: begin
          if (cnt_q == '0) res_st_d = ST_EMPTY;
          else             res_rd_d = t1v_q;
        end
        OP_DEL_HEAD: begin
          if (cnt_q != '0) begin
            if (cval_q && cur_q == head_q) cval_d = 1'b0;
            head_d = t1n_q;
            if (cnt_q > CW'(1)) begin
              wp_en = 1'b1; wp_a = t1n_q; wp_d = '0;
            end
            wn_en = 1'b1; wn_a = head_q; wn_d = fhead_q;
            fhead_d = head_q; fcnt_d = fcnt_q + CW'(1); cnt_d = cnt_q - CW'(1);
          end
        end
        OP_DEL_TAIL: begin
          if (cnt_q != '0) begin
            if (cval_q && cur_q == tail_q) cval_d = 1'b0;
            tail_d = t1p_q;
            if (cnt_q > CW'(1)) begin
              wn_en = 1'b1; wn_a = t1p_q; wn_d = '0;
            end
            w2n_en_d = 1'b1; w2n_a_d = tail_q; w2n_v_d = fhead_q;
            fhead_d = tail_q; fcnt_d = fcnt_q + CW'(1); cnt_d = cnt_q - CW'(1);
          end
        end
        OP_DEL_AFTER: begin
          if (cval_q && cur_q != tail_q) begin
            // unlink n = next of cursor, m = next of n
            if (t1n_q == tail_q) begin
              tail_d = cur_q;
            end else begin
              wp_en = 1'b1; wp_a = rdn_q; wp_d = cur_q;
            end
            wn_en = 1'b1; wn_a = cur_q; wn_d = rdn_q;
            w2n_en_d = 1'b1; w2n_a_d = t1n_q; w2n_v_d = fhead_q;
            fhead_d = t1n_q; fcnt_d = fcnt_q + CW'(1); cnt_d = cnt_q - CW'(1);
          end
        end
        OP_DEL_BEFORE: begin
          if (cval_q && cur_q != head_q) begin
            if (t1p_q == head_q) begin
              head_d = cur_q;
            end else begin
              wn_en = 1'b1; wn_a = rdp_q; wn_d = cur_q;
            end
            wp_en = 1'b1; wp_a = cur_q; wp_d = rdp_q;
            w2n_en_d = 1'b1; w2n_a_d = t1p_q; w2n_v_d = fhead_q;
            fhead_d = t1p_q; fcnt_d = fcnt_q + CW'(1); cnt_d = cnt_q - CW'(1);
          end
        end
        OP_INS_AFTER, OP_INS_BEFORE: begin
          if (cval_q) begin
            if (!tk_ok) begin
              res_st_d = ST_FULL;
            end else begin
              fhead_d = tk_fhead; fcnt_d = tk_fcnt; unused_d = tk_unused;
              wv_en = 1'b1; wv_a = tk_n; wv_d = val_q;
              wn_en = 1'b1; wn_a = tk_n;
              wp_en = 1'b1; wp_a = tk_n;
              if (op_q == OP_INS_AFTER) begin
                wn_d = t1n_q; wp_d = cur_q;
                if (cur_q == tail_q) begin
                  tail_d = tk_n;
                end else begin
                  w2p_en_d = 1'b1; w2p_a_d = t1n_q; w2p_v_d = tk_n;
                end
                w2n_en_d = 1'b1; w2n_a_d = cur_q; w2n_v_d = tk_n;
              end else begin
                wp_d = t1p_q; wn_d = cur_q;
                if (cur_q == head_q) begin
                  head_d = tk_n;
                end else begin
                  w2n_en_d = 1'b1; w2n_a_d = t1p_q; w2n_v_d = tk_n;
                end
                w2p_en_d = 1'b1; w2p_a_d = cur_q; w2p_v_d = tk_n;
              end
              cnt_d = cnt_q + CW'(1);
            end
          end
        end
        OP_GET_CUR: begin
          if (!cval_q) res_st_d = ST_EMPTY;
          else         res_rd_d = t1v_q;
        end
        OP_SET_CUR: begin
          if (cval_q) begin
            wv_en = 1'b1; wv_a = cur_q; wv_d = val_q;
          end
        end
        OP_NEXT: begin
          if (cval_q) begin
            if (cur_q == tail_q) cval_d = 1'b0;
            else                 cur_d = t1n_q;
          end
        end
        OP_PREV: begin
          if (cval_q) begin
            if (cur_q == head_q) cval_d = 1'b0;
            else                 cur_d = t1p_q;
          end
        end
        default: ;
      endcase
    end
  end

  // memories: one write and one registered read each per cycle
  always_ff @(posedge clk_i) begin
    if (wv_en) val_mem[wv_a] <= wv_d;
    if (cmd_i.wr2 ? w2n_en_q : wn_en) begin
      next_mem[cmd_i.wr2 ? w2n_a_q : wn_a] <= cmd_i.wr2 ? w2n_v_q : wn_d;
    end
    if (cmd_i.wr2 ? w2p_en_q : wp_en) begin
      prev_mem[cmd_i.wr2 ? w2p_a_q : wp_a] <= cmd_i.wr2 ? w2p_v_q : wp_d;
    end
    rdv_q <= val_mem[raddr];
    rdn_q <= next_mem[raddr];
    rdp_q <= prev_mem[raddr];
  end

  // list control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      cur_q    <= '0;
      cval_q   <= 1'b0;
      cnt_q    <= '0;
      unused_q <= '0;
      fhead_q  <= '0;
      fcnt_q   <= '0;
      w2n_en_q <= 1'b0;
      w2p_en_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      cur_q    <= cur_d;
      cval_q   <= cval_d;
      cnt_q    <= cnt_d;
      unused_q <= unused_d;
      fhead_q  <= fhead_d;
      fcnt_q   <= fcnt_d;
      if (cmd_i.wr1) begin
        w2n_en_q <= w2n_en_d;
        w2p_en_q <= w2p_en_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      val_q <= value_i;
    end
    if (cmd_i.rd2) begin
      t1v_q <= rdv_q;
      t1n_q <= rdn_q;
      t1p_q <= rdp_q;
    end
    if (cmd_i.wr1) begin
      w2n_a_q <= w2n_a_d;
      w2n_v_q <= w2n_v_d;
      w2p_a_q <= w2p_a_d;
      w2p_v_q <= w2p_v_d;
    end
    res_rd_q <= res_rd_d;
    res_st_q <= res_st_d;
    if (cmd_i.emit) begin
      read_value_o     <= res_rd_q;
      status_o         <= res_st_q;
      cursor_present_o <= cval_q;
      length_o         <= LEN_W'(cnt_q);
    end
  end

endmodule

// ===== hdl/doubly_linked_list_cursor_engine_unit.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_engine_unit
// Doubly linked list with a cursor over a fixed node pool.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  input   | in        | in_valid_i/in_ready_o  | op_i, value_i
//  output  | out       | out_valid_o/out_ready_i| read_value_o, status_o,
//          |           |                        | cursor_present_o, length_o
//
//  Each transaction steps through its phases in order, and no new input
//  is accepted until it is back in idle: the accept, two reads of the link
//  memories (for a delete beside the cursor the second read address comes
//  from the first read), two write phases, since an insert beside the
//  cursor writes each link memory twice, then the output load, which also
//  raises out_valid_o. Reset clears list, cursor and free chain registers;
//  the node memories are not cleared, entries are only used after being
//  written. A result waiting in the output register does not stop the next
//  input; a transaction only stalls in its output load if the previous
//  result is still not taken.
//
`include "doubly_linked_list_cursor_engine_unit_assert.svh"

module doubly_linked_list_cursor_engine_unit #(
  parameter int CAPACITY = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dllce_pkg::OP_W-1:0]          op_i,
  input  logic signed [dllce_pkg::VAL_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dllce_pkg::VAL_W-1:0]  read_value_o,
  output logic [dllce_pkg::ST_W-1:0]          status_o,
  output logic                                cursor_present_o,
  output logic [dllce_pkg::LEN_W-1:0]         length_o
);
  import dllce_pkg::*;

  cmd_t cmd;

  // sequence the phases of one transaction
  dllce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // node pool, list registers and result
  dllce_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .op_i             (op_i),
    .value_i          (value_i),
    .read_value_o     (read_value_o),
    .status_o         (status_o),
    .cursor_present_o (cursor_present_o),
    .length_o         (length_o)
  );

  // one transaction in flight: no accept right after an accept
  `DLLCE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // a failed read never carries data
  `DLLCE_ASSERT_SAME(a_empty_reads_zero, out_valid_o && status_o == ST_EMPTY, read_value_o == '0)

endmodule

// ===== sim/doubly_linked_list_cursor_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_engine_unit_tb
// Self-checking bench for the list cursor engine. A directed table covers
// empty reads, value extremes, every operation, cursor loss at the head end and
// unknown ops. A random phase then runs list-building sequences, including
// fills up to pool exhaustion. Each result is checked field by field against
// a typed expectation or a behavioral list model running in the bench.
// ----------------------------------------------------------------------------
module doubly_linked_list_cursor_engine_unit_tb;
  import dllce_pkg::*;

  localparam int          POOL_SIZE   = 256;
  localparam int          RAND_ITEMS  = 1700;
  localparam int          CALM_ITEMS  = 200;
  localparam int          STUCK_LIMIT = 5000;
  localparam int          DRAIN_WAIT  = 20;
  localparam logic [4:0]  OP_UNK_LO   = 5'd17;
  localparam logic [4:0]  OP_UNK_HI   = 5'd31;

  typedef struct packed {
    logic signed [31:0] rd;
    st_e                st;
    logic               cur;
    logic [8:0]         len;
  } list_result_t;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [31:0] val;
    logic               typed;   // expectation written into the row
    list_result_t       res;
  } table_row_t;

  // DUT connections
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [4:0]         op_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] read_value_o;
  logic [1:0]         status_o;
  logic               cursor_present_o;
  logic [8:0]         length_o;

  doubly_linked_list_cursor_engine_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .value_i,
    .out_valid_o, .out_ready_i, .read_value_o, .status_o,
    .cursor_present_o, .length_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow list state
  logic [31:0] shadow_val  [POOL_SIZE];
  logic [7:0]  shadow_next [POOL_SIZE];
  logic [7:0]  shadow_prev [POOL_SIZE];
  logic [7:0]  sh_head, sh_tail, sh_cur, sh_free_head;
  logic        sh_cur_ok;
  logic [8:0]  sh_count, sh_unused, sh_free_count;

  list_result_t expected_q[$];
  int           err_count  = 0;
  int           acc_count  = 0;
  int           stuck_cnt  = 0;
  bit           calm       = 1'b0;
  bit           row_typed  = 1'b0;
  list_result_t row_res;

  // Hand out a node from the free chain, else from the never-used pool.
  function automatic bit grab_node(output logic [7:0] n);
    n = '0;
    if (sh_free_count > 0) begin
      n = sh_free_head;
      sh_free_head = shadow_next[n];
      sh_free_count--;
      return 1'b1;
    end
    if (sh_unused < POOL_SIZE) begin
      n = sh_unused[7:0];
      sh_unused++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void drop_node(logic [7:0] n);
    shadow_next[n] = sh_free_head;
    sh_free_head = n;
    sh_free_count++;
  endfunction

  // Apply one operation to the shadow list and return the outcome.
  function automatic list_result_t apply_list_op(logic [4:0] op, logic [31:0] v);
    list_result_t r;
    logic [7:0] n, m, c;
    r.rd = '0;
    r.st = ST_OK;
    c = sh_cur;
    case (op)
      OP_CLEAR: begin
        sh_count = 0; sh_cur_ok = 1'b0; sh_unused = 0;
        sh_free_count = 0; sh_free_head = 0;
      end
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (!grab_node(n)) r.st = ST_FULL;
        else begin
          shadow_val[n] = v;
          if (op == OP_INS_HEAD) begin
            shadow_next[n] = sh_head; shadow_prev[n] = 0;
            if (sh_count == 0) sh_tail = n; else shadow_prev[sh_head] = n;
            sh_head = n;
          end else begin
            shadow_prev[n] = sh_tail; shadow_next[n] = 0;
            if (sh_count == 0) sh_head = n; else shadow_next[sh_tail] = n;
            sh_tail = n;
          end
          sh_count++;
        end
      end
      OP_CUR_HEAD, OP_CUR_TAIL: begin
        sh_cur = (op == OP_CUR_HEAD) ? sh_head : sh_tail;
        sh_cur_ok = sh_count > 0;
      end
      OP_GET_HEAD, OP_GET_TAIL: begin
        if (sh_count == 0) r.st = ST_EMPTY;
        else r.rd = shadow_val[(op == OP_GET_HEAD) ? sh_head : sh_tail];
      end
      OP_DEL_HEAD: if (sh_count != 0) begin
        n = sh_head;
        if (sh_cur_ok && c == n) sh_cur_ok = 1'b0;
        sh_head = shadow_next[n];
        if (sh_count > 1) shadow_prev[sh_head] = 0;
        drop_node(n);
        sh_count--;
      end
      OP_DEL_TAIL: if (sh_count != 0) begin
        n = sh_tail;
        if (sh_cur_ok && c == n) sh_cur_ok = 1'b0;
        sh_tail = shadow_prev[n];
        if (sh_count > 1) shadow_next[sh_tail] = 0;
        drop_node(n);
        sh_count--;
      end
      OP_DEL_AFTER: if (sh_cur_ok && c != sh_tail) begin
        n = shadow_next[c];
        m = shadow_next[n];
        if (n == sh_tail) sh_tail = c; else shadow_prev[m] = c;
        shadow_next[c] = m;
        drop_node(n);
        sh_count--;
      end
      OP_DEL_BEFORE: if (sh_cur_ok && c != sh_head) begin
        n = shadow_prev[c];
        m = shadow_prev[n];
        if (n == sh_head) sh_head = c; else shadow_next[m] = c;
        shadow_prev[c] = m;
        drop_node(n);
        sh_count--;
      end
      OP_INS_AFTER: if (sh_cur_ok) begin
        if (!grab_node(n)) r.st = ST_FULL;
        else begin
          shadow_val[n] = v;
          shadow_next[n] = shadow_next[c];
          shadow_prev[n] = c;
          if (c == sh_tail) sh_tail = n; else shadow_prev[shadow_next[c]] = n;
          shadow_next[c] = n;
          sh_count++;
        end
      end
      OP_INS_BEFORE: if (sh_cur_ok) begin
        if (!grab_node(n)) r.st = ST_FULL;
        else begin
          shadow_val[n] = v;
          shadow_prev[n] = shadow_prev[c];
          shadow_next[n] = c;
          if (c == sh_head) sh_head = n; else shadow_next[shadow_prev[c]] = n;
          shadow_prev[c] = n;
          sh_count++;
        end
      end
      OP_GET_CUR: begin
        if (!sh_cur_ok) r.st = ST_EMPTY; else r.rd = shadow_val[c];
      end
      OP_SET_CUR: if (sh_cur_ok) shadow_val[c] = v;
      OP_NEXT: if (sh_cur_ok) begin
        if (c == sh_tail) sh_cur_ok = 1'b0; else sh_cur = shadow_next[c];
      end
      OP_PREV: if (sh_cur_ok) begin
        if (c == sh_head) sh_cur_ok = 1'b0; else sh_cur = shadow_prev[c];
      end
      default: ;
    endcase
    r.cur = sh_cur_ok;
    r.len = sh_count;
    return r;
  endfunction

  // Accept side: predict each transaction at the edge that takes it.
  always @(posedge clk_i) begin
    list_result_t r;
    if (rst_ni && in_valid_i && in_ready_o) begin
      r = apply_list_op(op_i, value_i);
      expected_q.push_back(row_typed ? row_res : r);
      acc_count++;
    end
  end

  // Result side: compare against the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no expectation pending");
        err_count++;
      end else begin
        e = expected_q.pop_front();
        if (read_value_o !== e.rd) begin
          $error("read_value: expected %0d, got %0d", e.rd, read_value_o);
          err_count++;
        end
        if (status_o !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status_o);
          err_count++;
        end
        if (cursor_present_o !== e.cur) begin
          $error("cursor_present: expected %0b, got %0b", e.cur, cursor_present_o);
          err_count++;
        end
        if (length_o !== e.len) begin
          $error("length: expected %0d, got %0d", e.len, length_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without any transaction on either side.
  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))) begin
      stuck_cnt++;
      if (stuck_cnt >= STUCK_LIMIT) begin
        $display("doubly_linked_list_cursor_engine_unit_tb: FAIL");
        $finish;
      end
    end else begin
      stuck_cnt = 0;
    end
  end

  // Receiver back-pressure: stall in short bursts, none once calm.
  always @(negedge clk_i) begin
    int stall_left;
    logic rdy;
    rdy = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!calm && rst_ni && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      rdy = 1'b0;
    end
    out_ready_i = rdy;
  end

  // Present one transaction at the falling edge; hold until taken.
  // Entered and left at a falling edge.
  task automatic send_op(logic [4:0] op, logic [31:0] v, bit typed = 1'b0,
                         list_result_t res = '0);
    int seen;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    seen = acc_count;
    in_valid_i = 1'b1;
    op_i = op;
    value_i = v;
    row_typed = typed;
    row_res = res;
    while (acc_count == seen) @(negedge clk_i);
    // the next call replaces the payload or drops valid at this same edge
  endtask

  function automatic list_result_t mk_res(logic signed [31:0] rd, st_e st,
                                          logic cur, logic [8:0] len);
    list_result_t r;
    r.rd = rd; r.st = st; r.cur = cur; r.len = len;
    return r;
  endfunction

  // Pick an op that keeps the list busy: inserts when short, deletes when long.
  function automatic logic [4:0] pick_op();
    int w;
    w = $urandom_range(0, 99);
    if (w < 3) return 5'($urandom_range(OP_UNK_LO, OP_UNK_HI));
    if (w < 5) return OP_CLEAR;
    if (w < 35) begin
      if (sh_count > 40 && $urandom_range(0, 1))
        return 5'($urandom_range(OP_DEL_HEAD, OP_DEL_BEFORE));
      return 5'($urandom_range(0, 3) == 0 ? OP_INS_HEAD :
                $urandom_range(0, 2) == 0 ? OP_INS_TAIL :
                $urandom_range(OP_INS_AFTER, OP_INS_BEFORE));
    end
    if (w < 45) return 5'($urandom_range(OP_CUR_HEAD, OP_CUR_TAIL));
    if (w < 60) return 5'($urandom_range(OP_DEL_HEAD, OP_DEL_BEFORE));
    return 5'($urandom_range(OP_CUR_HEAD, OP_PREV));
  endfunction

  // Directed stimulus: typed expectations where obvious, else predicted.
  table_row_t directed[] = '{
    '{OP_GET_HEAD,   32'sd5,           1'b1, mk_res(0, ST_EMPTY, 0, 0)},
    '{OP_GET_CUR,    32'sd0,           1'b1, mk_res(0, ST_EMPTY, 0, 0)},
    '{OP_DEL_TAIL,   32'sd0,           1'b1, mk_res(0, ST_OK, 0, 0)},
    '{OP_CUR_HEAD,   32'sd0,           1'b1, mk_res(0, ST_OK, 0, 0)},
    '{OP_INS_HEAD,   32'h8000_0000,    1'b1, mk_res(0, ST_OK, 0, 1)},
    '{OP_INS_TAIL,   32'h7FFF_FFFF,    1'b1, mk_res(0, ST_OK, 0, 2)},
    '{OP_GET_HEAD,   32'sd0,           1'b1, mk_res(32'h8000_0000, ST_OK, 0, 2)},
    '{OP_GET_TAIL,   32'sd0,           1'b1, mk_res(32'h7FFF_FFFF, ST_OK, 0, 2)},
    '{OP_NEXT,       32'sd0,           1'b0, '0},
    '{OP_CUR_HEAD,   32'sd0,           1'b0, '0},
    '{OP_PREV,       32'sd0,           1'b0, '0},
    '{OP_CUR_TAIL,   32'sd0,           1'b0, '0},
    '{OP_INS_AFTER,  32'hFFFF_FFFF,    1'b0, '0},
    '{OP_INS_BEFORE, 32'sd12345,       1'b0, '0},
    '{OP_PREV,       32'sd0,           1'b0, '0},
    '{OP_DEL_BEFORE, 32'sd0,           1'b0, '0},
    '{OP_DEL_AFTER,  32'sd0,           1'b0, '0},
    '{OP_SET_CUR,    32'h5A5A_A5A5,    1'b0, '0},
    '{OP_GET_CUR,    32'sd0,           1'b0, '0},
    '{OP_NEXT,       32'sd0,           1'b0, '0},
    '{OP_DEL_HEAD,   32'sd0,           1'b0, '0},
    '{OP_UNK_LO,     32'sd1,           1'b0, '0},
    '{OP_UNK_HI,     32'sd1,           1'b0, '0},
    '{OP_CLEAR,      32'sd0,           1'b1, mk_res(0, ST_OK, 0, 0)},
    '{OP_CUR_TAIL,   32'sd0,           1'b1, mk_res(0, ST_OK, 0, 0)}
  };

  // Fill the pool with mixed inserts, then hammer it while full.
  task automatic fill_pool();
    logic [4:0] ops[4] = '{OP_INS_HEAD, OP_INS_TAIL, OP_INS_AFTER, OP_INS_BEFORE};
    send_op(OP_CLEAR, 0);
    send_op(OP_INS_TAIL, $urandom());
    send_op(OP_CUR_HEAD, 0);
    while (sh_count < POOL_SIZE) send_op(ops[$urandom_range(0, 3)], $urandom());
    foreach (ops[k]) send_op(ops[k], $urandom());
    send_op(OP_DEL_AFTER, 0);
    send_op(OP_INS_AFTER, $urandom());
    send_op(OP_INS_HEAD, $urandom());
  endtask

  initial begin
    int items;
    sh_head = 0; sh_tail = 0; sh_cur = 0; sh_cur_ok = 0;
    sh_count = 0; sh_unused = 0; sh_free_head = 0; sh_free_count = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i])
      send_op(directed[i].op, directed[i].val, directed[i].typed, directed[i].res);

    // Random phase, with two pool fills to reach exhaustion.
    items = 0;
    while (items < RAND_ITEMS) begin
      if (items == 300 || items == 1000) begin
        fill_pool();
        items += POOL_SIZE;
      end
      calm = (items > RAND_ITEMS - CALM_ITEMS);
      send_op(pick_op(), $urandom());
      items++;
    end

    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0)
      $display("doubly_linked_list_cursor_engine_unit_tb: PASS");
    else
      $display("doubly_linked_list_cursor_engine_unit_tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dllce_pkg.sv
hdl/dllce_ctrl.sv
hdl/dllce_dpath.sv
hdl/doubly_linked_list_cursor_engine_unit.sv
sim/doubly_linked_list_cursor_engine_unit_tb.sv
